// ===== rtl/mcomp_pkg.sv =====
// shared constants, types and helper functions of the magnetometer compensation block
package mcomp_pkg;

  // quotient bits produced by each pipelined divider, and its depth in registers
  localparam int DIV_QW   = 47;
  localparam int DIV_LAT  = DIV_QW + 1;
  // three stages ahead of the dividers, ten after them
  localparam int PIPE_LAT = DIV_LAT + 13;

  // configuration register indexes
  localparam logic [2:0] REG_TRIM_XY   = 3'd0;
  localparam logic [2:0] REG_TRIM_Z    = 3'd1;
  localparam logic [2:0] REG_TRIM_XYZ1 = 3'd2;
  localparam logic [2:0] REG_BIAS      = 3'd3;
  localparam logic [2:0] REG_SCALE     = 3'd4;
  localparam logic [2:0] REG_AXIS_MAP  = 3'd5;

  // mounting orientations, every other code passes the axes straight through
  localparam logic [2:0] MAP_NEG_Y_X_Z   = 3'd1;
  localparam logic [2:0] MAP_Y_NEG_X_Z   = 3'd3;
  localparam logic [2:0] MAP_NZ_NY_NX    = 3'd4;
  localparam logic [2:0] MAP_NZ_X_NY     = 3'd5;
  localparam logic [2:0] MAP_NZ_Y_X      = 3'd6;
  localparam logic [2:0] MAP_NZ_NX_Y     = 3'd7;

  // sensor overflow codes
  localparam logic [12:0] OVF_XY_RAW = 13'h1000;
  localparam logic [14:0] OVF_Z_RAW  = 15'h4000;

  localparam logic [47:0] SCALE_RESET = 48'h1000_1000_1000;
  // z quotient clamp, 2^46 in Q16
  localparam logic [46:0] ZCOMP_LIM   = 47'h4000_0000_0000;

  typedef struct packed {
    logic [12:0] rx;
    logic [12:0] ry;
    logic        zzero;
    logic        zsign;
  } mcomp_tag_t;

  function automatic logic signed [23:0] sat24(input logic signed [37:0] v);
    if (v > 38'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -38'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [23:0] neg24(input logic signed [23:0] v);
    if (v == 24'sh800000) begin
      return 24'sh7FFFFF;
    end
    return -v;
  endfunction

endpackage

// ===== rtl/mcomp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module mcomp_div #(
  parameter int NW = 63,
  parameter int DW = 32,
  parameter int QW = 47
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] low [QW];
  logic [DW-1:0] dv  [QW];
  logic [QW-1:0] q   [QW+1];
  logic          ov  [QW+1];
  logic [NW-1:0] hi;

  assign hi = num >> QW;

  // first stage registers; ov flags a quotient that would need more than QW bits
  always_ff @(posedge clk) begin
    rem[0] <= hi[DW-1:0];
    low[0] <= num[QW-1:0];
    dv[0]  <= den;
    q[0]   <= '0;
    ov[0]  <= hi >= NW'(den);
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] trial;

    assign trial = {rem[i], low[i][QW-1]} - {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      q[i+1]  <= {q[i][QW-2:0], ~trial[DW]};
      ov[i+1] <= ov[i];
    end

    if (i < QW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (!trial[DW]) begin
          rem[i+1] <= trial[DW-1:0];
        end else begin
          rem[i+1] <= {rem[i][DW-2:0], low[i][QW-1]};
        end
        low[i+1] <= low[i] << 1;
        dv[i+1]  <= dv[i];
      end
    end
  end

  assign quo = q[QW];
  assign ovf = ov[QW];

endmodule

// ===== rtl/magnetometer_compensation.sv =====
// top level: unpack, trim compensation, bias, gain and axis remap pipeline
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------
//  request   | start, busy          | data_burst
//  result    | done (one-cycle)     | field_x, field_y, field_z
//  config    | cfg_write, cfg_index | cfg_data
//
// one request per cycle while busy is low; results come out in request order
// most of the depth comes from the two dividers, 47 steps each (hall ratio and z quotient)
// requests with the ready bit clear or zero hall give no result
// rst is synchronous; busy is high only while rst is high
// the receiver cannot stall, so nothing ever holds in the pipeline
module magnetometer_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        data_burst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               done,
  output logic signed [23:0] field_x,
  output logic signed [23:0] field_y,
  output logic signed [23:0] field_z
);
  import mcomp_pkg::*;

  // configuration
  logic [47:0] trim_xy;
  logic [63:0] trim_z;
  logic [14:0] trim_xyz1;
  logic [47:0] bias_pack;
  logic [47:0] scale_pack;
  logic [2:0]  axis_map;

  logic signed [7:0]  xy_a1 [2];
  logic signed [7:0]  xy_a2 [2];
  logic signed [7:0]  xy2;
  logic [7:0]         xy1;
  logic [15:0]        z1;
  logic signed [15:0] z2, z3, z4;

  // stage a
  logic               a_valid;
  logic [12:0]        a_rx, a_ry;
  logic signed [14:0] a_rz;
  logic [13:0]        a_rhall;
  // stage b
  logic               b_valid;
  logic [12:0]        b_rx, b_ry;
  logic [13:0]        b_rhall;
  logic               b_zovf;
  logic signed [34:0] b_znum;
  logic signed [31:0] b_zden;
  logic signed [16:0] zdiff;
  logic signed [15:0] hdiff;
  logic signed [31:0] z3h;
  logic [29:0]        z1h;
  // stage c
  logic               c_valid;
  logic [12:0]        c_rx, c_ry;
  logic [13:0]        c_rhall;
  logic               c_zzero, c_zsign;
  logic [33:0]        c_nmag;
  logic [31:0]        c_dmag;
  logic [34:0]        znum_abs;
  logic [31:0]        zden_abs;
  // dividers and the line beside them
  logic [DIV_QW-1:0]  xy_quo, z_quo;
  logic               xy_ovf, z_ovf;
  logic               line_valid [DIV_LAT];
  mcomp_tag_t         line_tag   [DIV_LAT];
  mcomp_tag_t         d_tag;
  logic signed [47:0] rdiff;
  logic [46:0]        zmag;
  // stage e
  logic               e_valid;
  logic signed [31:0] e_r;
  logic [12:0]        e_rx, e_ry;
  logic signed [47:0] e_zcomp;
  logic signed [63:0] e_sq;
  // stage f
  logic               f_valid;
  logic [17:0]        f_t;
  logic signed [40:0] f_p;
  logic [12:0]        f_rx, f_ry;
  logic signed [47:0] f_zcomp;
  logic signed [40:0] p_adj;
  logic signed [26:0] xt;
  // stage g
  logic               g_valid;
  logic signed [27:0] g_cc;
  logic signed [12:0] g_raw [2];
  logic signed [47:0] g_zcomp;
  // stage h
  logic               h_valid;
  logic signed [40:0] h_m1 [2];
  logic               h_zero [2];
  logic signed [47:0] h_zcomp;
  // stage i
  logic               i_valid;
  logic signed [50:0] i_m2 [2];
  logic               i_zero [2];
  logic signed [47:0] i_zcomp;
  logic signed [9:0]  kgain [2];
  logic signed [50:0] m2_adj [2];
  // stages j to m
  logic               j_valid, k_valid, l_valid, m_valid;
  logic signed [47:0] j_comp [3];
  logic signed [48:0] k_d [3];
  logic signed [65:0] l_p [3];
  logic signed [65:0] l_adj [3];
  logic signed [23:0] m_m [3];

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_xy    <= '0;
      trim_z     <= '0;
      trim_xyz1  <= '0;
      bias_pack  <= '0;
      scale_pack <= SCALE_RESET;
      axis_map   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TRIM_XY:   trim_xy    <= cfg_data[47:0];
        REG_TRIM_Z:    trim_z     <= cfg_data;
        REG_TRIM_XYZ1: trim_xyz1  <= cfg_data[14:0];
        REG_BIAS:      bias_pack  <= cfg_data[47:0];
        REG_SCALE:     scale_pack <= cfg_data[47:0];
        REG_AXIS_MAP:  axis_map   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign xy_a1[0] = $signed(trim_xy[7:0]);
  assign xy_a1[1] = $signed(trim_xy[15:8]);
  assign xy_a2[0] = $signed(trim_xy[23:16]);
  assign xy_a2[1] = $signed(trim_xy[31:24]);
  assign xy2      = $signed(trim_xy[39:32]);
  assign xy1      = trim_xy[47:40];
  assign z1       = trim_z[15:0];
  assign z2       = $signed(trim_z[31:16]);
  assign z3       = $signed(trim_z[47:32]);
  assign z4       = $signed(trim_z[63:48]);

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        line_valid[i] <= 1'b0;
      end
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
      h_valid <= 1'b0;
      i_valid <= 1'b0;
      j_valid <= 1'b0;
      k_valid <= 1'b0;
      l_valid <= 1'b0;
      m_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= start && !busy && data_burst[48] && (data_burst[63:50] != '0);
      b_valid <= a_valid;
      c_valid <= b_valid;
      line_valid[0] <= c_valid;
      for (int i = 1; i < DIV_LAT; i++) begin
        line_valid[i] <= line_valid[i-1];
      end
      e_valid <= line_valid[DIV_LAT-1];
      f_valid <= e_valid;
      g_valid <= f_valid;
      h_valid <= g_valid;
      i_valid <= h_valid;
      j_valid <= i_valid;
      k_valid <= j_valid;
      l_valid <= k_valid;
      m_valid <= l_valid;
      done    <= m_valid;
    end
  end

  // z numerator and divisor
  assign zdiff = 17'(a_rz) - 17'(z4);
  assign hdiff = $signed({2'b00, a_rhall}) - $signed({1'b0, trim_xyz1});
  assign z3h   = z3 * hdiff;
  assign z1h   = z1 * a_rhall;

  // magnitudes for the z divider
  assign znum_abs = b_znum[34] ? 35'(-b_znum) : b_znum;
  assign zden_abs = b_zden[31] ? 32'(-b_zden) : b_zden;

  always_ff @(posedge clk) begin
    a_rx    <= data_burst[15:3];
    a_ry    <= data_burst[31:19];
    a_rz    <= $signed(data_burst[47:33]);
    a_rhall <= data_burst[63:50];

    b_rx    <= a_rx;
    b_ry    <= a_ry;
    b_rhall <= a_rhall;
    b_zovf  <= a_rz == OVF_Z_RAW;
    b_znum  <= 35'($signed({zdiff, 17'b0})) - 35'(z3h);
    b_zden  <= 32'($signed({z2, 15'b0})) + $signed({2'b00, z1h});

    c_rx    <= b_rx;
    c_ry    <= b_ry;
    c_rhall <= b_rhall;
    c_zzero <= b_zovf || (z1 == '0) || (z2 == '0) || (trim_xyz1 == '0) || (b_zden == '0);
    c_zsign <= b_znum[34] ^ b_zden[31];
    c_nmag  <= znum_abs[33:0];
    c_dmag  <= zden_abs;
  end

  mcomp_div #(.NW(48), .DW(14), .QW(DIV_QW)) u_div_xy (
    .clk (clk),
    .num ({3'b000, trim_xyz1, 30'b0}),
    .den (c_rhall),
    .quo (xy_quo),
    .ovf (xy_ovf)
  );

  mcomp_div #(.NW(63), .DW(32), .QW(DIV_QW)) u_div_z (
    .clk (clk),
    .num ({c_nmag, 29'b0}),
    .den (c_dmag),
    .quo (z_quo),
    .ovf (z_ovf)
  );

  always_ff @(posedge clk) begin
    line_tag[0] <= '{rx: c_rx, ry: c_ry, zzero: c_zzero, zsign: c_zsign};
    for (int i = 1; i < DIV_LAT; i++) begin
      line_tag[i] <= line_tag[i-1];
    end
  end

  assign d_tag = line_tag[DIV_LAT-1];
  assign rdiff = $signed({1'b0, xy_quo}) - 48'sd1073741824;
  assign zmag  = (z_ovf || (z_quo > ZCOMP_LIM)) ? ZCOMP_LIM : z_quo;

  // t = r^2 / 2^44, the xy2 term and the rounding of the xy1 term
  assign e_sq  = e_r * e_r;
  assign p_adj = f_p + $signed({27'b0, {14{f_p[40]}}});
  assign xt    = xy2 * $signed({1'b0, f_t});

  for (genvar ax = 0; ax < 2; ax++) begin : g_xy
    assign kgain[ax]  = 10'(xy_a2[ax]) + 10'sd160;
    assign m2_adj[ax] = i_m2[ax] + $signed({38'b0, {13{i_m2[ax][50]}}});
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_cal
    assign l_adj[ax] = l_p[ax] + $signed({38'b0, {28{l_p[ax][65]}}});
  end

  always_ff @(posedge clk) begin
    // hall ratio less one, scaled by 2^30 and clamped just under 2.0
    if (xy_ovf || (rdiff > 48'sd2147483647)) begin
      e_r <= 32'sh7FFFFFFF;
    end else begin
      e_r <= rdiff[31:0];
    end
    e_rx <= d_tag.rx;
    e_ry <= d_tag.ry;
    if (d_tag.zzero) begin
      e_zcomp <= '0;
    end else if (d_tag.zsign) begin
      e_zcomp <= -$signed({1'b0, zmag});
    end else begin
      e_zcomp <= $signed({1'b0, zmag});
    end

    f_t     <= e_sq[61:44];
    f_p     <= e_r * $signed({1'b0, xy1});
    f_rx    <= e_rx;
    f_ry    <= e_ry;
    f_zcomp <= e_zcomp;

    g_cc     <= 28'(xt) + 28'($signed(p_adj[40:14])) + 28'sd16777216;
    g_raw[0] <= $signed(f_rx);
    g_raw[1] <= $signed(f_ry);
    g_zcomp  <= f_zcomp;

    for (int i = 0; i < 2; i++) begin
      h_m1[i]   <= g_raw[i] * g_cc;
      h_zero[i] <= (g_raw[i] == $signed(OVF_XY_RAW)) || (trim_xyz1 == '0);
    end
    h_zcomp <= g_zcomp;

    for (int i = 0; i < 2; i++) begin
      i_m2[i]   <= h_m1[i] * kgain[i];
      i_zero[i] <= h_zero[i];
    end
    i_zcomp <= h_zcomp;

    for (int i = 0; i < 2; i++) begin
      if (i_zero[i]) begin
        j_comp[i] <= '0;
      end else begin
        j_comp[i] <= 48'($signed(m2_adj[i][50:13])) + 48'($signed({xy_a1[i], 19'b0}));
      end
    end
    j_comp[2] <= i_zcomp;

    for (int i = 0; i < 3; i++) begin
      k_d[i] <= 49'(j_comp[i]) - 49'($signed({bias_pack[16*i +: 16], 16'b0}));
      l_p[i] <= k_d[i] * $signed({1'b0, scale_pack[16*i +: 16]});
      m_m[i] <= sat24($signed(l_adj[i][65:28]));
    end

    case (axis_map)
      MAP_NEG_Y_X_Z: begin
        field_x <= neg24(m_m[1]);
        field_y <= m_m[0];
        field_z <= m_m[2];
      end
      MAP_Y_NEG_X_Z: begin
        field_x <= m_m[1];
        field_y <= neg24(m_m[0]);
        field_z <= m_m[2];
      end
      MAP_NZ_NY_NX: begin
        field_x <= neg24(m_m[2]);
        field_y <= neg24(m_m[1]);
        field_z <= neg24(m_m[0]);
      end
      MAP_NZ_X_NY: begin
        field_x <= neg24(m_m[2]);
        field_y <= m_m[0];
        field_z <= neg24(m_m[1]);
      end
      MAP_NZ_Y_X: begin
        field_x <= neg24(m_m[2]);
        field_y <= m_m[1];
        field_z <= m_m[0];
      end
      MAP_NZ_NX_Y: begin
        field_x <= neg24(m_m[2]);
        field_y <= neg24(m_m[0]);
        field_z <= m_m[1];
      end
      default: begin
        field_x <= m_m[0];
        field_y <= m_m[1];
        field_z <= m_m[2];
      end
    endcase
  end

endmodule

// ===== rtl/mcomp_checker.sv =====
// port-level assertions for the magnetometer compensation block, bound to the top level
module mcomp_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [63:0] data_burst,
  input logic        done
);
  import mcomp_pkg::*;

  // every result traces back to an accepted request
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching request");

  // a request with the ready bit clear gives no result
  a_not_ready_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !data_burst[48]) |-> ##PIPE_LAT !done)
    else $error("result for a request that was not ready");

  // a request with zero hall resistance gives no result
  a_zero_hall_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (data_burst[63:50] == 14'd0)) |-> ##PIPE_LAT !done)
    else $error("result for a request with zero hall value");

endmodule

bind magnetometer_compensation mcomp_checker u_mcomp_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .data_burst (data_burst),
  .done       (done)
);

// ===== sim/magnetometer_compensation_checker.sv =====
// checker: predicts compensated field results from the request stream and compares them
`timescale 1ns / 100ps

module magnetometer_compensation_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [63:0]        data_burst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               done,
  input  logic signed [23:0] field_x,
  input  logic signed [23:0] field_y,
  input  logic signed [23:0] field_z,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);
  import mcomp_pkg::*;

  typedef struct packed {
    logic signed [23:0] fx;
    logic signed [23:0] fy;
    logic signed [23:0] fz;
  } field_t;

  logic [47:0] trim_xy_q;
  logic [63:0] trim_z_q;
  logic [14:0] xyz1_q;
  logic [47:0] bias_q;
  logic [47:0] scale_q;
  logic [2:0]  map_q;
  field_t      expected_fields[$];

  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint hall_poly(input longint raw, input longint rhall,
                                       input longint a1, input longint a2);
    longint xyz1, xy2, xy1, r, t, c2, c4;
    xyz1 = longint'(xyz1_q);
    xy2  = longint'($signed(trim_xy_q[39:32]));
    xy1  = longint'(trim_xy_q[47:40]);
    if (raw == -4096 || xyz1 == 0 || rhall == 0) return 0;
    r = ((xyz1 << 30) / rhall) - 64'sd1073741824;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    t = longint'(64'(r * r) >> 44);
    c2 = xy2 * t + (r * xy1) / 16384;
    c4 = raw * (c2 + 64'sd16777216) * (a2 + 160);
    return c4 / 8192 + a1 * 8 * 65536;
  endfunction

  function automatic longint z_ratio(input longint raw, input longint rhall);
    longint xyz1, z1, z2, z3, z4, num, e, q;
    xyz1 = longint'(xyz1_q);
    z1 = longint'(trim_z_q[15:0]);
    z2 = longint'($signed(trim_z_q[31:16]));
    z3 = longint'($signed(trim_z_q[47:32]));
    z4 = longint'($signed(trim_z_q[63:48]));
    if (raw == -16384 || z1 == 0 || z2 == 0 || xyz1 == 0 || rhall == 0) return 0;
    e = z2 * 32768 + z1 * rhall;
    if (e == 0) return 0;
    num = (raw - z4) * 131072 - z3 * (rhall - xyz1);
    q = (num * 64'sd536870912) / e;
    if (q > 64'sd70368744177664) q = 64'sd70368744177664;
    if (q < -64'sd70368744177664) q = -64'sd70368744177664;
    return q;
  endfunction

  function automatic longint calibrate(input longint comp, input int axis);
    longint bias, gain;
    bias = longint'($signed(bias_q[16*axis +: 16]));
    gain = longint'(scale_q[16*axis +: 16]);
    return clamp24(((comp - bias * 65536) * gain) / 64'sd268435456);
  endfunction

  // returns 0 when the burst produces no result
  function automatic bit predict_fields(input logic [63:0] d, output field_t f);
    longint rhall, rx, ry, rz, mx, my, mz, ox, oy, oz;
    if (!d[48]) return 0;
    rhall = longint'(d[63:50]);
    if (rhall == 0) return 0;
    rx = longint'($signed(d[15:3]));
    ry = longint'($signed(d[31:19]));
    rz = longint'($signed(d[47:33]));
    mx = calibrate(hall_poly(rx, rhall, longint'($signed(trim_xy_q[7:0])),
                             longint'($signed(trim_xy_q[23:16]))), 0);
    my = calibrate(hall_poly(ry, rhall, longint'($signed(trim_xy_q[15:8])),
                             longint'($signed(trim_xy_q[31:24]))), 1);
    mz = calibrate(z_ratio(rz, rhall), 2);
    case (map_q)
      MAP_NEG_Y_X_Z: begin ox = -my; oy = mx;  oz = mz;  end
      MAP_Y_NEG_X_Z: begin ox = my;  oy = -mx; oz = mz;  end
      MAP_NZ_NY_NX:  begin ox = -mz; oy = -my; oz = -mx; end
      MAP_NZ_X_NY:   begin ox = -mz; oy = mx;  oz = -my; end
      MAP_NZ_Y_X:    begin ox = -mz; oy = my;  oz = mx;  end
      MAP_NZ_NX_Y:   begin ox = -mz; oy = -mx; oz = my;  end
      default:       begin ox = mx;  oy = my;  oz = mz;  end
    endcase
    f.fx = 24'(clamp24(ox));
    f.fy = 24'(clamp24(oy));
    f.fz = 24'(clamp24(oz));
    return 1;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  assign pending = expected_fields.size();

  initial begin
    errors = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    field_t f;
    field_t e;
    if (rst) begin
      trim_xy_q <= '0;
      trim_z_q  <= '0;
      xyz1_q    <= '0;
      bias_q    <= '0;
      scale_q   <= SCALE_RESET;
      map_q     <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TRIM_XY:   trim_xy_q <= cfg_data[47:0];
          REG_TRIM_Z:    trim_z_q  <= cfg_data;
          REG_TRIM_XYZ1: xyz1_q    <= cfg_data[14:0];
          REG_BIAS:      bias_q    <= cfg_data[47:0];
          REG_SCALE:     scale_q   <= cfg_data[47:0];
          REG_AXIS_MAP:  map_q     <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (start && !busy && predict_fields(data_burst, f)) expected_fields.push_back(f);
      if (done) begin
        results_seen++;
        if (expected_fields.size() == 0) begin
          report($sformatf("unexpected result %0d %0d %0d", field_x, field_y, field_z));
        end else begin
          e = expected_fields.pop_front();
          if (field_x !== e.fx) report($sformatf("field_x %0d, want %0d", field_x, e.fx));
          if (field_y !== e.fy) report($sformatf("field_y %0d, want %0d", field_y, e.fy));
          if (field_z !== e.fz) report($sformatf("field_z %0d, want %0d", field_z, e.fz));
        end
      end
    end
  end

endmodule

// ===== sim/magnetometer_compensation_tb.sv =====
// testbench top: clock, reset, request and register stimulus, verdict
`timescale 1ns / 100ps

module magnetometer_compensation_tb;
  import mcomp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 11;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [63:0]        data_burst = '0;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               done;
  logic signed [23:0] field_x, field_y, field_z;
  int                 errors, pending, results_seen;
  int                 cycles = 0;
  int                 requests = 0;

  always #5 clk = ~clk;

  magnetometer_compensation DUT (.*);

  magnetometer_compensation_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic [63:0] d, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    data_burst <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests++;
  endtask

  function automatic logic [63:0] pack_burst(input logic [12:0] x, input logic [12:0] y,
                                             input logic [14:0] z, input logic [13:0] rhall,
                                             input logic ready);
    logic [63:0] d;
    d = {$urandom, $urandom};
    d[15:3] = x;
    d[31:19] = y;
    d[47:33] = z;
    d[48] = ready;
    d[63:50] = rhall;
    return d;
  endfunction

  function automatic logic [63:0] random_burst();
    logic [63:0] d;
    int k;
    d = {$urandom, $urandom};
    k = $urandom_range(0, 99);
    if (k < 88) begin
      d[48] = 1'b1;
      if ($urandom_range(0, 9) < 7) d[63:50] = 14'($urandom_range(5000, 8000));
      else d[63:50] = 14'($urandom_range(1, 16383));
      if ($urandom_range(0, 29) == 0) d[15:3] = OVF_XY_RAW;
      if ($urandom_range(0, 29) == 0) d[31:19] = OVF_XY_RAW;
      if ($urandom_range(0, 29) == 0) d[47:33] = OVF_Z_RAW;
    end else if (k < 92) begin
      d[48] = 1'b1;
      d[63:50] = '0;
    end
    return d;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // wait out the pipeline so no request in flight sees a new setting
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic set_phase(input int ph);
    logic [47:0] txy, bias, gain;
    logic [63:0] tz;
    logic [14:0] xyz1;
    logic [2:0]  amap;
    case (ph)
      1: begin
        txy = {8'd29, -8'sd3, 8'd26, 8'd26, 8'd0, 8'd0};
        tz = {16'd0, 16'd0, 16'd763, 16'd24747};
        xyz1 = 15'd6909; bias = '0; gain = SCALE_RESET; amap = 3'd0;
      end
      2: begin
        txy = '1; tz = '1; xyz1 = '1; bias = '1; gain = '1; amap = 3'd7;
      end
      3: begin
        txy = {8'hFF, 8'h80, 8'h7F, 8'h7F, 8'h80, 8'h80};
        tz = {16'h8000, 16'h7FFF, 16'h8000, 16'h0001};
        xyz1 = 15'd1; bias = {16'h8000, 16'h7FFF, 16'h8000}; gain = '1; amap = 3'd1;
      end
      10: begin
        txy = '0; tz = '0; xyz1 = '0; bias = '0; gain = '0; amap = 3'd0;
      end
      default: begin
        txy = {$urandom, $urandom};
        tz = {$urandom, $urandom};
        if ($urandom_range(0, 1)) tz[31:0] = {16'($urandom_range(500, 900)),
                                              16'($urandom_range(20000, 30000))};
        xyz1 = ($urandom_range(0, 1)) ? 15'($urandom_range(6000, 7500)) : 15'($urandom);
        bias = {3{16'($signed(16'($urandom_range(0, 2000))) - 16'sd1000)}};
        if ($urandom_range(0, 3) == 0) bias = {$urandom, $urandom};
        gain = {16'($urandom_range(2048, 8192)), 16'($urandom), 16'($urandom_range(2048, 8192))};
        amap = 3'(ph - 2);
      end
    endcase
    write_reg(REG_TRIM_XY, 64'(txy));
    write_reg(REG_TRIM_Z, tz);
    write_reg(REG_TRIM_XYZ1, 64'(xyz1));
    write_reg(REG_BIAS, 64'(bias));
    write_reg(REG_SCALE, 64'(gain));
    write_reg(REG_AXIS_MAP, 64'(amap));
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        set_phase(ph);
      end
      if (ph == 1) begin
        // ready clear, zero hall, overflow codes, raw and hall extremes
        send_request(pack_burst(13'd100, 13'd100, 15'd100, 14'd6500, 1'b0), 0);
        send_request(pack_burst(13'd100, 13'd100, 15'd100, 14'd0, 1'b1), 0);
        send_request(pack_burst(OVF_XY_RAW, 13'd200, 15'd300, 14'd6500, 1'b1), 0);
        send_request(pack_burst(13'd200, OVF_XY_RAW, 15'd300, 14'd6500, 1'b1), 0);
        send_request(pack_burst(13'd200, 13'd300, OVF_Z_RAW, 14'd6500, 1'b1), 0);
        send_request(pack_burst(13'h0FFF, 13'h0FFF, 15'h3FFF, 14'd6909, 1'b1), 0);
        send_request(pack_burst(13'h1001, 13'h1001, 15'h4001, 14'd6909, 1'b1), 1);
        send_request(pack_burst(13'd0, 13'd0, 15'd0, 14'd6909, 1'b1), 0);
        send_request(pack_burst(13'h0FFF, 13'h1001, 15'h3FFF, 14'd1, 1'b1), 0);
        send_request(pack_burst(13'h1001, 13'h0FFF, 15'h4001, 14'h3FFF, 1'b1), 2);
        send_request(pack_burst(13'h1FFF, 13'd1, 15'h7FFF, 14'd100, 1'b1), 0);
        send_request(pack_burst(13'd1, 13'h1FFF, 15'd1, 14'd12000, 1'b1), 0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_request(64'h0000_0000_0000_0000, 0);
      end
      repeat (175) send_request(random_burst(), pick_gap());
    end
    drain();
    $display("%0d requests over %0d register settings, all eight axis remaps", requests,
             PHASES);
    $display("%0d results checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
